>>> sv/ecam_pkg.sv
`timescale 1ns / 1ps
// Types, constants and helper functions shared by the fly camera modules
package ecam_pkg;

	localparam int TRIG_ITERATIONS = 16;
	localparam int ITER_W = $clog2(TRIG_ITERATIONS);

	localparam int DEG90 = 5898240;
	localparam int DEG180 = 11796480;
	localparam int DEG360 = 23592960;
	localparam longint ANG_BIAS = 64'd92 * 64'd23592960;
	localparam int PITCH_LIM = 5832704;
	localparam int ZOOM_MIN = 256;
	localparam int ZOOM_MAX = 19200;
	localparam int ZOOM_RESET = 11520;
	localparam int ONE_Q14 = 16384;
	localparam int CORDIC_GAIN = 652032874;
	localparam int ONE_Q30 = 1073741824;
	localparam int YAW_RESET = -5898240;
	localparam int SPEED_RESET = 640;
	localparam int SENS_RESET = 6554;

	localparam logic [2:0] REG_MOVE_SPEED = 3'd0;
	localparam logic [2:0] REG_MOUSE_SENS = 3'd1;
	localparam logic [2:0] REG_WORLD_UP_X = 3'd2;
	localparam logic [2:0] REG_WORLD_UP_Y = 3'd3;
	localparam logic [2:0] REG_WORLD_UP_Z = 3'd4;
	localparam logic [2:0] REG_INIT_ZOOM = 3'd5;

	typedef enum logic [1:0] {CMD_MOVE, CMD_LOOK, CMD_SCROLL, CMD_PLACE} cmd_t;
	typedef enum logic [1:0] {DIR_FWD, DIR_BACK, DIR_LEFT, DIR_RIGHT} dir_t;
	typedef enum logic [1:0] {VEC_FRONT, VEC_RIGHT, VEC_UP} vsel_t;

	typedef enum logic [4:0] {
		S_IDLE, S_MV_VEL, S_MV_LD, S_MV_MUL, S_MV_ACC,
		S_LK_YM, S_LK_YA, S_LK_PM, S_LK_PA, S_SCROLL,
		S_CY_GO, S_CY_WAIT, S_CP_GO, S_CP_WAIT,
		S_F0, S_F2, S_F2ST, S_SQ, S_NM_GO, S_NM_WAIT, S_CX, S_OUT
	} cam_state_t;

	typedef enum logic [2:0] {C_IDLE, C_RED, C_FOLD, C_ROT, C_FIN} cor_state_t;
	typedef enum logic [2:0] {N_IDLE, N_SQRT, N_DSET, N_DIV, N_STORE} nrm_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -34'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
		logic signed [31:0] r;
		unique case (i)
			5'd0: r = 32'sd2949120;
			5'd1: r = 32'sd1740967;
			5'd2: r = 32'sd919879;
			5'd3: r = 32'sd466945;
			5'd4: r = 32'sd234379;
			5'd5: r = 32'sd117304;
			5'd6: r = 32'sd58666;
			5'd7: r = 32'sd29335;
			5'd8: r = 32'sd14668;
			5'd9: r = 32'sd7334;
			5'd10: r = 32'sd3667;
			5'd11: r = 32'sd1833;
			5'd12: r = 32'sd917;
			5'd13: r = 32'sd458;
			5'd14: r = 32'sd229;
			5'd15: r = 32'sd115;
			5'd16: r = 32'sd57;
			5'd17: r = 32'sd29;
			5'd18: r = 32'sd14;
			5'd19: r = 32'sd7;
			5'd20: r = 32'sd4;
			5'd21: r = 32'sd2;
			5'd22: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage

>>> sv/ecam_cordic.sv
`timescale 1ns / 1ps
// Iterative sine and cosine of a Q16.16 degree angle, results in Q1.30
module ecam_cordic (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [31:0] angle,
	output logic done,
	output logic signed [31:0] sin_val,
	output logic signed [31:0] cos_val
);

	ecam_pkg::cor_state_t state_q, state_d;
	logic [33:0] u_q;
	logic [2:0] k_q;
	logic [ecam_pkg::ITER_W-1:0] i_q;
	logic signed [33:0] x_q, y_q;
	logic signed [31:0] z_q;
	logic flip_q;
	logic [33:0] red_sub;
	logic signed [26:0] fold_r0, fold_r1, fold_r;
	logic fold_flip;
	logic signed [33:0] dx, dy, xf, yf, xc, yc;
	logic signed [31:0] atan_v;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ecam_pkg::C_IDLE: if (start) state_d = ecam_pkg::C_RED;
			ecam_pkg::C_RED: if (k_q == 3'd0) state_d = ecam_pkg::C_FOLD;
			ecam_pkg::C_FOLD: state_d = ecam_pkg::C_ROT;
			ecam_pkg::C_ROT: begin
				if (i_q == ecam_pkg::ITER_W'(ecam_pkg::TRIG_ITERATIONS - 1))
					state_d = ecam_pkg::C_FIN;
			end
			ecam_pkg::C_FIN: state_d = ecam_pkg::C_IDLE;
			default: state_d = ecam_pkg::C_IDLE;
		endcase
	end

	always_comb begin
		red_sub = 34'(ecam_pkg::DEG360) << k_q;
		fold_r0 = $signed({1'b0, u_q[25:0]});
		fold_r1 = (fold_r0 > 27'(ecam_pkg::DEG180)) ? fold_r0 - 27'(ecam_pkg::DEG360)
			: fold_r0;
		fold_flip = 1'b0;
		fold_r = fold_r1;
		if (fold_r1 > 27'(ecam_pkg::DEG90)) begin
			fold_r = fold_r1 - 27'(ecam_pkg::DEG180);
			fold_flip = 1'b1;
		end else if (fold_r1 < -27'(ecam_pkg::DEG90)) begin
			fold_r = fold_r1 + 27'(ecam_pkg::DEG180);
			fold_flip = 1'b1;
		end
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		atan_v = ecam_pkg::atan_deg(5'(i_q));
		xf = flip_q ? -x_q : x_q;
		yf = flip_q ? -y_q : y_q;
		if (xf > 34'(ecam_pkg::ONE_Q30))
			xc = 34'(ecam_pkg::ONE_Q30);
		else if (xf < -34'(ecam_pkg::ONE_Q30))
			xc = -34'(ecam_pkg::ONE_Q30);
		else
			xc = xf;
		if (yf > 34'(ecam_pkg::ONE_Q30))
			yc = 34'(ecam_pkg::ONE_Q30);
		else if (yf < -34'(ecam_pkg::ONE_Q30))
			yc = -34'(ecam_pkg::ONE_Q30);
		else
			yc = yf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ecam_pkg::C_IDLE;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= (state_q == ecam_pkg::C_FIN);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ecam_pkg::C_IDLE: begin
				u_q <= 34'($signed(angle)) + 34'(ecam_pkg::ANG_BIAS);
				k_q <= 3'd7;
			end
			ecam_pkg::C_RED: begin
				if (u_q >= red_sub) u_q <= u_q - red_sub;
				k_q <= k_q - 3'd1;
			end
			ecam_pkg::C_FOLD: begin
				z_q <= 32'(fold_r);
				x_q <= 34'(ecam_pkg::CORDIC_GAIN);
				y_q <= '0;
				flip_q <= fold_flip;
				i_q <= '0;
			end
			ecam_pkg::C_ROT: begin
				if (!z_q[31]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_v;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_v;
				end
				i_q <= i_q + 1'b1;
			end
			ecam_pkg::C_FIN: begin
				cos_val <= xc[31:0];
				sin_val <= yc[31:0];
			end
			default: ;
		endcase
	end

endmodule

>>> sv/ecam_norm.sv
`timescale 1ns / 1ps
// Vector normalizer: bit-serial square root, then a restoring divide per component
module ecam_norm (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] sum_sq,
	input logic signed [31:0] vec [3],
	output logic done,
	output logic signed [15:0] unit_vec [3]
);

	ecam_pkg::nrm_state_t state_q, state_d;
	logic [63:0] s_q, r_q, bit_v, rb;
	logic [4:0] it_q;
	logic [1:0] k_q;
	logic [3:0] b_q;
	logic [45:0] rem_q, dsh_q;
	logic [14:0] q_q, qc;
	logic signed [31:0] v_q [3];
	logic [31:0] len, mag;
	logic signed [15:0] comp;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ecam_pkg::N_IDLE: if (start) state_d = ecam_pkg::N_SQRT;
			ecam_pkg::N_SQRT: if (it_q == 5'd31) state_d = ecam_pkg::N_DSET;
			ecam_pkg::N_DSET: state_d = ecam_pkg::N_DIV;
			ecam_pkg::N_DIV: if (b_q == 4'd14) state_d = ecam_pkg::N_STORE;
			ecam_pkg::N_STORE: begin
				state_d = (k_q == 2'd2) ? ecam_pkg::N_IDLE : ecam_pkg::N_DSET;
			end
			default: state_d = ecam_pkg::N_IDLE;
		endcase
	end

	always_comb begin
		bit_v = 64'd1 << (6'd62 - {it_q, 1'b0});
		rb = r_q + bit_v;
		len = r_q[31:0];
		mag = v_q[k_q][31] ? 32'(-v_q[k_q]) : 32'(v_q[k_q]);
		qc = (q_q > 15'(ecam_pkg::ONE_Q14)) ? 15'(ecam_pkg::ONE_Q14) : q_q;
		if (len == 32'd0)
			comp = '0;
		else if (v_q[k_q][31])
			comp = -$signed({1'b0, qc});
		else
			comp = $signed({1'b0, qc});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ecam_pkg::N_IDLE;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= (state_q == ecam_pkg::N_STORE) && (k_q == 2'd2);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ecam_pkg::N_IDLE: begin
				s_q <= sum_sq;
				r_q <= '0;
				it_q <= '0;
				k_q <= '0;
				v_q <= vec;
			end
			ecam_pkg::N_SQRT: begin
				if (s_q >= rb) begin
					s_q <= s_q - rb;
					r_q <= (r_q >> 1) + bit_v;
				end else begin
					r_q <= r_q >> 1;
				end
				it_q <= it_q + 5'd1;
			end
			ecam_pkg::N_DSET: begin
				rem_q <= {mag, 14'b0} + 46'(len >> 1);
				dsh_q <= {len, 14'b0};
				q_q <= '0;
				b_q <= '0;
			end
			ecam_pkg::N_DIV: begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					q_q <= {q_q[13:0], 1'b1};
				end else begin
					q_q <= {q_q[13:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
				b_q <= b_q + 4'd1;
			end
			ecam_pkg::N_STORE: begin
				unit_vec[k_q] <= comp;
				k_q <= k_q + 2'd1;
			end
			default: ;
		endcase
	end

endmodule

>>> sv/euler_fly_camera_update.sv
`timescale 1ns / 1ps
// Fly camera pose update: move, look, scroll and place commands on a fixed-point pose
// One request at a time. Look and place rebuild the front, right and up vectors
// through two passes of the iterative rotation unit, 16 rotation steps each, and three
// passes through the normalizer (32-step square root and a 15-step divide per component).
// All products go through one registered 33 by 33 multiplier. The result sits in an
// output register, so the next request is taken while it waits; configuration writes
// act at once.
module euler_fly_camera_update (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] command,
	input logic [1:0] direction,
	input logic [15:0] delta_time,
	input logic signed [15:0] x_offset,
	input logic signed [15:0] y_offset,
	input logic constrain_pitch,
	input logic signed [31:0] place_x,
	input logic signed [31:0] place_y,
	input logic signed [31:0] place_z,
	input logic signed [31:0] place_yaw,
	input logic signed [31:0] place_pitch,
	output logic out_valid,
	input logic out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [15:0] front_x,
	output logic signed [15:0] front_y,
	output logic signed [15:0] front_z,
	output logic signed [15:0] up_x,
	output logic signed [15:0] up_y,
	output logic signed [15:0] up_z,
	output logic [14:0] zoom_out,
	output logic signed [31:0] yaw_out,
	output logic signed [31:0] pitch_out,
	input logic cfg_write,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data
);

	ecam_pkg::cam_state_t state_q, state_d;
	ecam_pkg::cmd_t cmd_in;
	ecam_pkg::dir_t dir_q;
	ecam_pkg::vsel_t vsel_q;
	logic [15:0] dt_q;
	logic signed [15:0] xo_q, yo_q;
	logic cpitch_q;
	logic [15:0] speed_q, sens_q;
	logic signed [15:0] wu_q [3];
	logic signed [31:0] pos_q [3];
	logic signed [31:0] yaw_q, pitch_q;
	logic [14:0] zoom_q;
	logic signed [15:0] front_q [3];
	logic signed [15:0] right_q [3];
	logic signed [15:0] up_q [3];
	logic [31:0] vel_q;
	logic signed [65:0] prod_q;
	logic signed [31:0] tmp_q;
	logic signed [31:0] w_q [3];
	logic [63:0] acc_q;
	logic [1:0] k_q, sq_idx, cx_idx;
	logic [2:0] j_q;
	logic signed [31:0] sy_q, cy_q, sp_q, cp_q;

	logic signed [32:0] mul_a, mul_b;
	logic cor_start, cor_done, nrm_start, nrm_done;
	logic signed [31:0] cor_angle, cor_sin, cor_cos;
	logic signed [15:0] nrm_out [3];
	logic signed [15:0] cx_a [3];
	logic signed [15:0] cx_b [3];
	logic signed [15:0] mv_vec;
	logic mv_neg;
	logic signed [65:0] mv_rnd, lk_rnd, f_rnd;
	logic signed [33:0] mv_sum, yaw_sum, pit_sum;
	logic signed [31:0] pit_sat, pit_new;
	logic signed [21:0] sc_z;
	logic [14:0] sc_new, cfg_zoom;

	assign cmd_in = ecam_pkg::cmd_t'(command);

	ecam_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cor_start),
		.angle(cor_angle),
		.done(cor_done),
		.sin_val(cor_sin),
		.cos_val(cor_cos)
	);

	ecam_norm u_norm (
		.clk(clk),
		.arst_n(arst_n),
		.start(nrm_start),
		.sum_sq(acc_q),
		.vec(w_q),
		.done(nrm_done),
		.unit_vec(nrm_out)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ecam_pkg::S_IDLE: begin
				if (in_valid) begin
					unique case (cmd_in)
						ecam_pkg::CMD_MOVE: state_d = ecam_pkg::S_MV_VEL;
						ecam_pkg::CMD_LOOK: state_d = ecam_pkg::S_LK_YM;
						ecam_pkg::CMD_SCROLL: state_d = ecam_pkg::S_SCROLL;
						ecam_pkg::CMD_PLACE: state_d = ecam_pkg::S_CY_GO;
						default: state_d = ecam_pkg::S_IDLE;
					endcase
				end
			end
			ecam_pkg::S_MV_VEL: state_d = ecam_pkg::S_MV_LD;
			ecam_pkg::S_MV_LD: state_d = ecam_pkg::S_MV_MUL;
			ecam_pkg::S_MV_MUL: state_d = ecam_pkg::S_MV_ACC;
			ecam_pkg::S_MV_ACC: begin
				state_d = (k_q == 2'd2) ? ecam_pkg::S_OUT : ecam_pkg::S_MV_MUL;
			end
			ecam_pkg::S_LK_YM: state_d = ecam_pkg::S_LK_YA;
			ecam_pkg::S_LK_YA: state_d = ecam_pkg::S_LK_PM;
			ecam_pkg::S_LK_PM: state_d = ecam_pkg::S_LK_PA;
			ecam_pkg::S_LK_PA: state_d = ecam_pkg::S_CY_GO;
			ecam_pkg::S_SCROLL: state_d = ecam_pkg::S_OUT;
			ecam_pkg::S_CY_GO: state_d = ecam_pkg::S_CY_WAIT;
			ecam_pkg::S_CY_WAIT: if (cor_done) state_d = ecam_pkg::S_CP_GO;
			ecam_pkg::S_CP_GO: state_d = ecam_pkg::S_CP_WAIT;
			ecam_pkg::S_CP_WAIT: if (cor_done) state_d = ecam_pkg::S_F0;
			ecam_pkg::S_F0: state_d = ecam_pkg::S_F2;
			ecam_pkg::S_F2: state_d = ecam_pkg::S_F2ST;
			ecam_pkg::S_F2ST: state_d = ecam_pkg::S_SQ;
			ecam_pkg::S_SQ: if (k_q == 2'd3) state_d = ecam_pkg::S_NM_GO;
			ecam_pkg::S_NM_GO: state_d = ecam_pkg::S_NM_WAIT;
			ecam_pkg::S_NM_WAIT: begin
				if (nrm_done)
					state_d = (vsel_q == ecam_pkg::VEC_UP) ? ecam_pkg::S_OUT
						: ecam_pkg::S_CX;
			end
			ecam_pkg::S_CX: if (j_q == 3'd6) state_d = ecam_pkg::S_SQ;
			ecam_pkg::S_OUT: if (!out_valid || out_ready) state_d = ecam_pkg::S_IDLE;
			default: state_d = ecam_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ecam_pkg::S_IDLE);
		cor_start = (state_q == ecam_pkg::S_CY_GO) || (state_q == ecam_pkg::S_CP_GO);
		cor_angle = (state_q == ecam_pkg::S_CP_GO) ? pitch_q : yaw_q;
		nrm_start = (state_q == ecam_pkg::S_NM_GO);
	end

	always_comb begin
		mv_vec = (dir_q == ecam_pkg::DIR_FWD || dir_q == ecam_pkg::DIR_BACK) ? front_q[k_q]
			: right_q[k_q];
		mv_neg = (dir_q == ecam_pkg::DIR_BACK || dir_q == ecam_pkg::DIR_LEFT);
		sq_idx = (k_q == 2'd3) ? 2'd0 : k_q;
		cx_idx = 2'(j_q[2:1] - 2'd1);
		for (int n = 0; n < 3; n++) begin
			cx_a[n] = (vsel_q == ecam_pkg::VEC_RIGHT) ? front_q[n] : right_q[n];
			cx_b[n] = (vsel_q == ecam_pkg::VEC_RIGHT) ? wu_q[n] : front_q[n];
		end
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ecam_pkg::S_MV_VEL: begin
				mul_a = $signed({17'b0, speed_q});
				mul_b = $signed({17'b0, dt_q});
			end
			ecam_pkg::S_MV_MUL: begin
				mul_a = 33'(mv_vec);
				mul_b = $signed({1'b0, vel_q});
			end
			ecam_pkg::S_LK_YM: begin
				mul_a = 33'(xo_q);
				mul_b = $signed({17'b0, sens_q});
			end
			ecam_pkg::S_LK_PM: begin
				mul_a = 33'(yo_q);
				mul_b = $signed({17'b0, sens_q});
			end
			ecam_pkg::S_F0: begin
				mul_a = 33'(cy_q);
				mul_b = 33'(cp_q);
			end
			ecam_pkg::S_F2: begin
				mul_a = 33'(sy_q);
				mul_b = 33'(cp_q);
			end
			ecam_pkg::S_SQ: begin
				mul_a = 33'(w_q[sq_idx]);
				mul_b = 33'(w_q[sq_idx]);
			end
			ecam_pkg::S_CX: begin
				unique case (j_q)
					3'd0: begin mul_a = 33'(cx_a[1]); mul_b = 33'(cx_b[2]); end
					3'd1: begin mul_a = 33'(cx_a[2]); mul_b = 33'(cx_b[1]); end
					3'd2: begin mul_a = 33'(cx_a[2]); mul_b = 33'(cx_b[0]); end
					3'd3: begin mul_a = 33'(cx_a[0]); mul_b = 33'(cx_b[2]); end
					3'd4: begin mul_a = 33'(cx_a[0]); mul_b = 33'(cx_b[1]); end
					3'd5: begin mul_a = 33'(cx_a[1]); mul_b = 33'(cx_b[0]); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		mv_rnd = (prod_q + 66'sd2097152) >>> 22;
		mv_sum = mv_neg ? 34'(pos_q[k_q]) - mv_rnd[33:0] : 34'(pos_q[k_q]) + mv_rnd[33:0];
		lk_rnd = (prod_q + 66'sd8) >>> 4;
		yaw_sum = 34'(yaw_q) + lk_rnd[33:0];
		pit_sum = 34'(pitch_q) + lk_rnd[33:0];
		pit_sat = ecam_pkg::sat32(pit_sum);
		pit_new = pit_sat;
		if (cpitch_q) begin
			if (pit_sat > 32'(ecam_pkg::PITCH_LIM))
				pit_new = 32'(ecam_pkg::PITCH_LIM);
			else if (pit_sat < -32'(ecam_pkg::PITCH_LIM))
				pit_new = -32'(ecam_pkg::PITCH_LIM);
		end
		f_rnd = (prod_q + 66'sd536870912) >>> 30;
		sc_z = $signed({7'b0, zoom_q}) - ($signed({{6{yo_q[15]}}, yo_q}) <<< 4);
		if (sc_z < 22'(ecam_pkg::ZOOM_MIN))
			sc_new = 15'(ecam_pkg::ZOOM_MIN);
		else if (sc_z > 22'(ecam_pkg::ZOOM_MAX))
			sc_new = 15'(ecam_pkg::ZOOM_MAX);
		else
			sc_new = sc_z[14:0];
		if (cfg_data[14:0] < 15'(ecam_pkg::ZOOM_MIN))
			cfg_zoom = 15'(ecam_pkg::ZOOM_MIN);
		else if (cfg_data[14:0] > 15'(ecam_pkg::ZOOM_MAX))
			cfg_zoom = 15'(ecam_pkg::ZOOM_MAX);
		else
			cfg_zoom = cfg_data[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ecam_pkg::S_IDLE;
			out_valid <= 1'b0;
			speed_q <= 16'(ecam_pkg::SPEED_RESET);
			sens_q <= 16'(ecam_pkg::SENS_RESET);
			wu_q[0] <= '0;
			wu_q[1] <= 16'(ecam_pkg::ONE_Q14);
			wu_q[2] <= '0;
			pos_q[0] <= '0;
			pos_q[1] <= '0;
			pos_q[2] <= '0;
			yaw_q <= 32'(ecam_pkg::YAW_RESET);
			pitch_q <= '0;
			zoom_q <= 15'(ecam_pkg::ZOOM_RESET);
			front_q[0] <= '0;
			front_q[1] <= '0;
			front_q[2] <= -16'(ecam_pkg::ONE_Q14);
			right_q[0] <= 16'(ecam_pkg::ONE_Q14);
			right_q[1] <= '0;
			right_q[2] <= '0;
			up_q[0] <= '0;
			up_q[1] <= 16'(ecam_pkg::ONE_Q14);
			up_q[2] <= '0;
			vsel_q <= ecam_pkg::VEC_FRONT;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				unique case (cfg_index)
					ecam_pkg::REG_MOVE_SPEED: speed_q <= cfg_data;
					ecam_pkg::REG_MOUSE_SENS: sens_q <= cfg_data;
					ecam_pkg::REG_WORLD_UP_X: wu_q[0] <= $signed(cfg_data);
					ecam_pkg::REG_WORLD_UP_Y: wu_q[1] <= $signed(cfg_data);
					ecam_pkg::REG_WORLD_UP_Z: wu_q[2] <= $signed(cfg_data);
					ecam_pkg::REG_INIT_ZOOM: zoom_q <= cfg_zoom;
					default: ;
				endcase
			end
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				ecam_pkg::S_IDLE: begin
					if (in_valid && cmd_in == ecam_pkg::CMD_PLACE) begin
						pos_q[0] <= place_x;
						pos_q[1] <= place_y;
						pos_q[2] <= place_z;
						yaw_q <= place_yaw;
						pitch_q <= place_pitch;
					end
				end
				ecam_pkg::S_MV_ACC: pos_q[k_q] <= ecam_pkg::sat32(mv_sum);
				ecam_pkg::S_LK_YA: yaw_q <= ecam_pkg::sat32(yaw_sum);
				ecam_pkg::S_LK_PA: pitch_q <= pit_new;
				ecam_pkg::S_SCROLL: zoom_q <= sc_new;
				ecam_pkg::S_F2ST: vsel_q <= ecam_pkg::VEC_FRONT;
				ecam_pkg::S_NM_WAIT: begin
					if (nrm_done) begin
						unique case (vsel_q)
							ecam_pkg::VEC_FRONT: begin
								front_q <= nrm_out;
								vsel_q <= ecam_pkg::VEC_RIGHT;
							end
							ecam_pkg::VEC_RIGHT: begin
								right_q <= nrm_out;
								vsel_q <= ecam_pkg::VEC_UP;
							end
							default: up_q <= nrm_out;
						endcase
					end
				end
				ecam_pkg::S_OUT: if (!out_valid || out_ready) out_valid <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ecam_pkg::S_IDLE: begin
				dir_q <= ecam_pkg::dir_t'(direction);
				dt_q <= delta_time;
				xo_q <= x_offset;
				yo_q <= y_offset;
				cpitch_q <= constrain_pitch;
				k_q <= '0;
			end
			ecam_pkg::S_MV_LD: vel_q <= prod_q[31:0];
			ecam_pkg::S_MV_ACC: k_q <= k_q + 2'd1;
			ecam_pkg::S_CY_WAIT: begin
				if (cor_done) begin
					sy_q <= cor_sin;
					cy_q <= cor_cos;
				end
			end
			ecam_pkg::S_CP_WAIT: begin
				if (cor_done) begin
					sp_q <= cor_sin;
					cp_q <= cor_cos;
				end
			end
			ecam_pkg::S_F2: w_q[0] <= f_rnd[31:0];
			ecam_pkg::S_F2ST: begin
				w_q[1] <= sp_q;
				w_q[2] <= f_rnd[31:0];
				k_q <= '0;
			end
			ecam_pkg::S_SQ: begin
				if (k_q == 2'd1)
					acc_q <= prod_q[63:0];
				else if (k_q != 2'd0)
					acc_q <= acc_q + prod_q[63:0];
				k_q <= k_q + 2'd1;
			end
			ecam_pkg::S_NM_WAIT: j_q <= '0;
			ecam_pkg::S_CX: begin
				if (j_q[0])
					tmp_q <= prod_q[31:0];
				else if (j_q != 3'd0)
					w_q[cx_idx] <= tmp_q - prod_q[31:0];
				j_q <= j_q + 3'd1;
				k_q <= '0;
			end
			ecam_pkg::S_OUT: begin
				if (!out_valid || out_ready) begin
					pos_x <= pos_q[0];
					pos_y <= pos_q[1];
					pos_z <= pos_q[2];
					front_x <= front_q[0];
					front_y <= front_q[1];
					front_z <= front_q[2];
					up_x <= up_q[0];
					up_y <= up_q[1];
					up_z <= up_q[2];
					zoom_out <= zoom_q;
					yaw_out <= yaw_q;
					pitch_out <= pitch_q;
				end
			end
			default: ;
		endcase
	end

	a_cor_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == ecam_pkg::S_CY_WAIT || state_q == ecam_pkg::S_CP_WAIT))
		else $error("rotation unit finished outside a wait state");

	a_nrm_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		nrm_done |-> (state_q == ecam_pkg::S_NM_WAIT))
		else $error("normalizer finished outside its wait state");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request taken while one is in progress");

	a_zoom_range: assert property (@(posedge clk) disable iff (!arst_n)
		zoom_q >= 15'(ecam_pkg::ZOOM_MIN) && zoom_q <= 15'(ecam_pkg::ZOOM_MAX))
		else $error("zoom left its range");

	a_front_unit: assert property (@(posedge clk) disable iff (!arst_n)
		front_q[0] >= -16'sd16384 && front_q[0] <= 16'sd16384 &&
		front_q[1] >= -16'sd16384 && front_q[1] <= 16'sd16384 &&
		front_q[2] >= -16'sd16384 && front_q[2] <= 16'sd16384)
		else $error("front component beyond unit length");

endmodule
